### design/mts_pkg.sv
package mts_pkg;

	localparam int MAX_TAG_NAME = 12;
	localparam int TAG_LEN_W    = $clog2(MAX_TAG_NAME + 1);
	localparam int MAX_RES      = 6;
	localparam int RES_CNT_W    = $clog2(MAX_RES + 1);
	localparam int HELD_MAX     = 4;
	localparam int HELD_CNT_W   = $clog2(HELD_MAX + 1);
	localparam int HELD_IDX_W   = $clog2(HELD_MAX);
	localparam int NUM_ENT      = 5;
	localparam int NUM_BLK      = 11;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} result_t;

	// All result words caused by one input word, slot 0 goes out first.
	typedef struct packed {
		logic [RES_CNT_W-1:0]     count;
		logic                     done;
		logic [MAX_RES-1:0][7:0]  bytes;
	} burst_t;

	function automatic logic [7:0] to_lower(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
	endfunction

	function automatic logic [TAG_LEN_W-1:0] blk_len(int p);
		logic [TAG_LEN_W-1:0] n;
		case (p)
			0: n = TAG_LEN_W'(2);
			1: n = TAG_LEN_W'(1);
			2: n = TAG_LEN_W'(2);
			3: n = TAG_LEN_W'(3);
			10: n = TAG_LEN_W'(10);
			default: n = TAG_LEN_W'(2);
		endcase
		return n;
	endfunction

	function automatic logic [7:0] blk_char(int p, logic [TAG_LEN_W-1:0] i);
		logic [79:0] s;
		case (p)
			0: s = {"br", 64'd0};
			1: s = {"p", 72'd0};
			2: s = {"li", 64'd0};
			3: s = {"div", 56'd0};
			4: s = {"tr", 64'd0};
			5: s = {"ul", 64'd0};
			6: s = {"ol", 64'd0};
			7: s = {"h1", 64'd0};
			8: s = {"h2", 64'd0};
			9: s = {"h3", 64'd0};
			default: s = "blockquote";
		endcase
		if (i >= TAG_LEN_W'(10)) begin
			return 8'd0;
		end
		return s[79 - 8 * int'(i) -: 8];
	endfunction

	function automatic logic [HELD_CNT_W-1:0] ent_len(int e);
		logic [HELD_CNT_W-1:0] n;
		case (e)
			0: n = HELD_CNT_W'(4);
			1: n = HELD_CNT_W'(3);
			2: n = HELD_CNT_W'(3);
			default: n = HELD_CNT_W'(5);
		endcase
		return n;
	endfunction

	function automatic logic [7:0] ent_char(int e, logic [HELD_CNT_W-1:0] k);
		logic [39:0] s;
		case (e)
			0: s = {"amp;", 8'd0};
			1: s = {"lt;", 16'd0};
			2: s = {"gt;", 16'd0};
			3: s = "nbsp;";
			default: s = "quot;";
		endcase
		if (k >= HELD_CNT_W'(5)) begin
			return 8'd0;
		end
		return s[39 - 8 * int'(k) -: 8];
	endfunction

	function automatic logic [7:0] ent_val(int e);
		logic [7:0] v;
		case (e)
			0: v = 8'h26;
			1: v = 8'h3C;
			2: v = 8'h3E;
			3: v = 8'h20;
			default: v = 8'h22;
		endcase
		return v;
	endfunction

endpackage

### design/mts_parser.sv
module mts_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  mts_pkg::item_t  item,
	input  logic            buf_ready,
	output logic            load,
	output mts_pkg::burst_t burst
);

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_TAG  = 2'd1,
		MODE_ENT  = 2'd2
	} mode_t;

	mts_pkg::item_t item_s1;
	logic           valid_s1;

	mode_t                                mode_q, mode_nx;
	logic [mts_pkg::HELD_CNT_W-1:0]       held_cnt_q, held_cnt_nx;
	logic [7:0]                           held_q  [mts_pkg::HELD_MAX];
	logic [7:0]                           held_nx [mts_pkg::HELD_MAX];
	logic [mts_pkg::NUM_ENT-1:0]          alive_q, alive_nx;
	logic [mts_pkg::TAG_LEN_W-1:0]        name_len_q, name_len_nx;
	logic                                 closed_q, closed_nx;
	logic                                 over_q, over_nx;
	logic [mts_pkg::NUM_BLK-1:0]          plain_q, plain_nx;
	logic [mts_pkg::NUM_BLK-1:0]          slash_q, slash_nx;
	logic                                 full_q, full_nx;
	logic                                 prev_full_q, prev_full_nx;
	logic                                 last_slash_q, last_slash_nx;

	logic [7:0]                           b, lb;
	logic [mts_pkg::NUM_ENT-1:0]          ent_ok, ent_fin;
	logic [7:0]                           ent_out;
	logic [mts_pkg::NUM_BLK-1:0]          plain_step, slash_step;
	logic [mts_pkg::TAG_LEN_W-1:0]        len_step;
	logic                                 full_step;
	logic                                 tag_block;
	logic                                 run_text;
	logic [mts_pkg::RES_CNT_W-1:0]        flush_cnt;
	logic                                 tail_en;
	logic [7:0]                           tail;
	logic                                 done;
	logic                                 process;

	assign b  = item_s1.in_byte;
	assign lb = mts_pkg::to_lower(b);

	// Entity match: alive_q marks the entities that the held bytes still prefix.
	always_comb begin
		ent_out = 8'd0;
		for (int e = 0; e < mts_pkg::NUM_ENT; e++) begin
			ent_ok[e] = alive_q[e] && (held_cnt_q < mts_pkg::ent_len(e)) &&
				(mts_pkg::ent_char(e, held_cnt_q) == lb);
			ent_fin[e] = ent_ok[e] &&
				(held_cnt_q + mts_pkg::HELD_CNT_W'(1) == mts_pkg::ent_len(e));
		end
		for (int e = mts_pkg::NUM_ENT - 1; e >= 0; e--) begin
			if (ent_fin[e]) begin
				ent_out = mts_pkg::ent_val(e);
			end
		end
	end

	// Tag name match runs one character at a time. full_q says the name so far is a
	// block tag, prev_full_q says the same of the name without its last character,
	// which is what counts when that last character is a slash.
	always_comb begin
		len_step  = name_len_q + mts_pkg::TAG_LEN_W'(1);
		full_step = 1'b0;
		for (int p = 0; p < mts_pkg::NUM_BLK; p++) begin
			plain_step[p] = plain_q[p] && (name_len_q < mts_pkg::blk_len(p)) &&
				(mts_pkg::blk_char(p, name_len_q) == lb);
			if (name_len_q == '0) begin
				slash_step[p] = (p != 0) && (lb == mts_pkg::CH_SLASH);
			end else begin
				slash_step[p] = slash_q[p] &&
					(name_len_q - mts_pkg::TAG_LEN_W'(1) < mts_pkg::blk_len(p)) &&
					(mts_pkg::blk_char(p, name_len_q - mts_pkg::TAG_LEN_W'(1)) == lb);
			end
			if ((plain_step[p] && len_step == mts_pkg::blk_len(p)) ||
				(slash_step[p] &&
				len_step == mts_pkg::blk_len(p) + mts_pkg::TAG_LEN_W'(1))) begin
				full_step = 1'b1;
			end
		end
		tag_block = !over_q && (last_slash_q ? prev_full_q : full_q);
	end

	always_comb begin
		mode_nx       = mode_q;
		held_cnt_nx   = held_cnt_q;
		held_nx       = held_q;
		alive_nx      = alive_q;
		name_len_nx   = name_len_q;
		closed_nx     = closed_q;
		over_nx       = over_q;
		plain_nx      = plain_q;
		slash_nx      = slash_q;
		full_nx       = full_q;
		prev_full_nx  = prev_full_q;
		last_slash_nx = last_slash_q;
		run_text      = 1'b0;
		flush_cnt     = '0;
		tail_en       = 1'b0;
		tail          = b;
		done          = 1'b0;

		if (item_s1.end_of_text) begin
			if (mode_q == MODE_ENT) begin
				flush_cnt = mts_pkg::RES_CNT_W'(held_cnt_q) + mts_pkg::RES_CNT_W'(1);
			end
			mode_nx     = MODE_TEXT;
			held_cnt_nx = '0;
			name_len_nx = '0;
			closed_nx   = 1'b0;
			over_nx     = 1'b0;
			tail_en     = 1'b1;
			tail        = 8'd0;
			done        = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_TAG: begin
					if (b == mts_pkg::CH_GT) begin
						mode_nx = MODE_TEXT;
						if (tag_block) begin
							tail_en = 1'b1;
							tail    = mts_pkg::CH_NL;
						end
					end else if (!closed_q) begin
						if (b == mts_pkg::CH_SP || b == mts_pkg::CH_TAB ||
							b == mts_pkg::CH_NL) begin
							closed_nx = 1'b1;
						end else if (name_len_q >= mts_pkg::TAG_LEN_W'(mts_pkg::MAX_TAG_NAME)) begin
							over_nx = 1'b1;
						end else begin
							name_len_nx   = len_step;
							plain_nx      = plain_step;
							slash_nx      = slash_step;
							full_nx       = full_step;
							prev_full_nx  = full_q;
							last_slash_nx = (lb == mts_pkg::CH_SLASH);
						end
					end
				end
				MODE_ENT: begin
					if (|ent_fin) begin
						tail_en     = 1'b1;
						tail        = ent_out;
						mode_nx     = MODE_TEXT;
						held_cnt_nx = '0;
					end else if (|ent_ok) begin
						held_nx[held_cnt_q[mts_pkg::HELD_IDX_W-1:0]] = b;
						held_cnt_nx = held_cnt_q + mts_pkg::HELD_CNT_W'(1);
						alive_nx    = ent_ok;
					end else begin
						// Not an entity after all: the held text goes out as it came,
						// then this byte is taken as plain text.
						flush_cnt = mts_pkg::RES_CNT_W'(held_cnt_q) + mts_pkg::RES_CNT_W'(1);
						mode_nx     = MODE_TEXT;
						held_cnt_nx = '0;
						run_text    = 1'b1;
					end
				end
				default: begin
					run_text = 1'b1;
				end
			endcase
		end

		if (run_text) begin
			if (b == mts_pkg::CH_LT) begin
				mode_nx       = MODE_TAG;
				name_len_nx   = '0;
				closed_nx     = 1'b0;
				over_nx       = 1'b0;
				plain_nx      = '1;
				slash_nx      = '0;
				full_nx       = 1'b0;
				prev_full_nx  = 1'b0;
				last_slash_nx = 1'b0;
			end else if (b == mts_pkg::CH_AMP) begin
				mode_nx     = MODE_ENT;
				held_cnt_nx = '0;
				alive_nx    = '1;
			end else begin
				tail_en = 1'b1;
			end
		end
	end

	always_comb begin
		burst.bytes = '0;
		burst.bytes[0] = mts_pkg::CH_AMP;
		for (int i = 1; i <= mts_pkg::HELD_MAX; i++) begin
			burst.bytes[i] = held_q[i-1];
		end
		for (int i = 0; i < mts_pkg::MAX_RES; i++) begin
			if (tail_en && flush_cnt == mts_pkg::RES_CNT_W'(i)) begin
				burst.bytes[i] = tail;
			end
		end
		burst.count = flush_cnt + mts_pkg::RES_CNT_W'(tail_en);
		burst.done  = done;
	end

	// A word with no results needs no room in the result buffer.
	assign process    = valid_s1 && (burst.count == '0 || buf_ready);
	assign load       = process && burst.count != '0;
	assign item_ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mode_q      <= MODE_TEXT;
			held_cnt_q  <= '0;
			name_len_q  <= '0;
			closed_q    <= 1'b0;
			over_q      <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (process) begin
				valid_s1 <= 1'b0;
			end
			if (process) begin
				mode_q     <= mode_nx;
				held_cnt_q <= held_cnt_nx;
				name_len_q <= name_len_nx;
				closed_q   <= closed_nx;
				over_q     <= over_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (process) begin
			held_q       <= held_nx;
			alive_q      <= alive_nx;
			plain_q      <= plain_nx;
			slash_q      <= slash_nx;
			full_q       <= full_nx;
			prev_full_q  <= prev_full_nx;
			last_slash_q <= last_slash_nx;
		end
	end

endmodule

### design/mts_burst_buf.sv
module mts_burst_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mts_pkg::burst_t  burst,
	output logic             buf_ready,
	output logic             result_valid,
	input  logic             result_ready,
	output mts_pkg::result_t result
);

	logic [7:0]                    bytes_q [mts_pkg::MAX_RES];
	logic [mts_pkg::RES_CNT_W-1:0] cnt_q;
	logic [mts_pkg::RES_CNT_W-1:0] idx_q;
	logic                          done_q;
	logic                          last;

	assign result_valid = idx_q != cnt_q;
	assign last         = idx_q + mts_pkg::RES_CNT_W'(1) == cnt_q;
	assign buf_ready    = !result_valid || (last && result_ready);

	assign result.out_byte  = bytes_q[idx_q];
	assign result.run_last  = last;
	assign result.text_done = done_q && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			done_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= burst.count;
			idx_q  <= '0;
			done_q <= burst.done;
		end else if (result_valid && result_ready) begin
			idx_q <= idx_q + mts_pkg::RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < mts_pkg::MAX_RES; i++) begin
				bytes_q[i] <= burst.bytes[i];
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q)
		else $error("read index ran past the stored word count");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (idx_q == cnt_q) ||
			(result_ready && idx_q + mts_pkg::RES_CNT_W'(1) == cnt_q))
		else $error("burst loaded over words not yet delivered");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> cnt_q != '0 && cnt_q <= mts_pkg::RES_CNT_W'(mts_pkg::MAX_RES))
		else $error("loaded burst count out of range");

endmodule

### design/markup_tag_stripper_top.sv
// Markup tag stripper: turns marked-up text into plain text, one byte per word.
// Input channel item_valid/item_ready/item carries in_byte and end_of_text.
// Output channel result_valid/result_ready/result carries out_byte, run_last and
// text_done; run_last marks the last result word caused by one input word.
// An accepted word sits in the input register, where the parser works it out and
// loads its results (zero to six words) into the result buffer when it has room.
// The first result word is offered from the result buffer register, which is
// loaded from the input register that holds the accepted input word.
// Throughput is one input word per cycle while each word causes at most one
// result and result_ready stays high, the buffer delivering one word per cycle;
// a word with several results holds the result buffer until its last is taken.
// Words without results (tag contents, held entity bytes) pass at one per cycle
// without using the buffer. When the receiver stalls, the buffer holds its words
// and the input register holds the next input word; item_ready drops once both
// are full. Reset returns the parser to normal text mode and empties both stages.
module markup_tag_stripper_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  mts_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output mts_pkg::result_t result
);

	mts_pkg::burst_t burst;
	logic            load;
	logic            buf_ready;

	mts_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.buf_ready  (buf_ready),
		.load       (load),
		.burst      (burst)
	);

	mts_burst_buf u_burst_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.burst        (burst),
		.buf_ready    (buf_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### sim/strip_checker.sv
`timescale 1ns / 100ps

module strip_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  mts_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  mts_pkg::result_t result,
	output int               fail_count,
	output int               pending
);

	localparam logic [7:0] CH_QUOT = 8'h22;

	typedef enum logic [1:0] {PM_TEXT, PM_TAG, PM_ENT} strip_mode_e;

	strip_mode_e pmode = PM_TEXT;
	logic [7:0]  held [5];
	int          held_n = 0;
	logic [7:0]  name_buf [mts_pkg::MAX_TAG_NAME];
	int          name_n = 0;
	bit          name_closed = 1'b0;
	bit          name_over = 1'b0;
	int          errs = 0;

	mts_pkg::result_t burst_q [$];
	mts_pkg::result_t plain_q [$];

	function automatic logic [7:0] fold_case(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
	endfunction

	function automatic string entity_spell(int e);
		case (e)
			0: return "amp;";
			1: return "lt;";
			2: return "gt;";
			3: return "nbsp;";
			default: return "quot;";
		endcase
	endfunction

	function automatic logic [7:0] entity_value(int e);
		case (e)
			0: return mts_pkg::CH_AMP;
			1: return mts_pkg::CH_LT;
			2: return mts_pkg::CH_GT;
			3: return mts_pkg::CH_SP;
			default: return CH_QUOT;
		endcase
	endfunction

	function automatic string block_name(int i);
		case (i)
			0: return "br";
			1: return "p";
			2: return "li";
			3: return "div";
			4: return "tr";
			5: return "ul";
			6: return "ol";
			7: return "h1";
			8: return "h2";
			9: return "h3";
			default: return "blockquote";
		endcase
	endfunction

	// A closing form of a block name counts too, except for br.
	function automatic bit names_block(int m);
		int    first;
		string s;
		bit    hit;
		first = 0;
		if (m > 0 && name_buf[0] == mts_pkg::CH_SLASH) begin
			first = 1;
		end
		for (int i = 0; i < mts_pkg::NUM_BLK; i++) begin
			if (first == 1 && i == 0) begin
				continue;
			end
			s = block_name(i);
			if (s.len() != m - first) begin
				continue;
			end
			hit = 1'b1;
			for (int j = 0; j < s.len(); j++) begin
				if (name_buf[first + j] != s[j]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic emit_word(logic [7:0] b, logic done);
		mts_pkg::result_t r;
		r.out_byte  = b;
		r.run_last  = 1'b0;
		r.text_done = done;
		if (burst_q.size() < mts_pkg::MAX_RES) begin
			burst_q.push_back(r);
		end
	endtask

	task automatic text_step(logic [7:0] b);
		if (b == mts_pkg::CH_LT) begin
			pmode       = PM_TAG;
			name_n      = 0;
			name_closed = 1'b0;
			name_over   = 1'b0;
		end else if (b == mts_pkg::CH_AMP) begin
			pmode  = PM_ENT;
			held_n = 0;
		end else begin
			emit_word(b, 1'b0);
		end
	endtask

	task automatic tag_step(logic [7:0] b);
		int m;
		if (b == mts_pkg::CH_GT) begin
			m     = name_n;
			pmode = PM_TEXT;
			if (name_over) begin
				return;
			end
			if (m > 0 && name_buf[m - 1] == mts_pkg::CH_SLASH) begin
				m--;
			end
			if (names_block(m)) begin
				emit_word(mts_pkg::CH_NL, 1'b0);
			end
			return;
		end
		if (name_closed) begin
			return;
		end
		if (b == mts_pkg::CH_SP || b == mts_pkg::CH_TAB || b == mts_pkg::CH_NL) begin
			name_closed = 1'b1;
		end else if (name_n >= mts_pkg::MAX_TAG_NAME) begin
			name_over = 1'b1;
		end else begin
			name_buf[name_n] = fold_case(b);
			name_n++;
		end
	endtask

	task automatic flush_entity();
		emit_word(mts_pkg::CH_AMP, 1'b0);
		for (int i = 0; i < held_n; i++) begin
			emit_word(held[i], 1'b0);
		end
		held_n = 0;
		pmode  = PM_TEXT;
	endtask

	task automatic entity_step(logic [7:0] b);
		int         k;
		logic [7:0] lb;
		bit         prefix;
		bit         ok;
		string      s;
		k      = held_n;
		lb     = fold_case(b);
		prefix = 1'b0;
		for (int e = 0; e < mts_pkg::NUM_ENT; e++) begin
			s  = entity_spell(e);
			ok = k < s.len() && s[k] == lb;
			for (int i = 0; ok && i < k; i++) begin
				if (fold_case(held[i]) != s[i]) begin
					ok = 1'b0;
				end
			end
			if (!ok) begin
				continue;
			end
			if (k + 1 == s.len()) begin
				emit_word(entity_value(e), 1'b0);
				held_n = 0;
				pmode  = PM_TEXT;
				return;
			end
			prefix = 1'b1;
		end
		if (prefix && k < 5) begin
			held[k] = b;
			held_n  = k + 1;
			return;
		end
		// The breaking byte is taken as fresh text once the held run is out.
		flush_entity();
		text_step(b);
	endtask

	task automatic strip_word(mts_pkg::item_t w);
		mts_pkg::result_t r;
		burst_q.delete();
		if (w.end_of_text) begin
			if (pmode == PM_ENT) begin
				flush_entity();
			end
			pmode       = PM_TEXT;
			held_n      = 0;
			name_n      = 0;
			name_closed = 1'b0;
			name_over   = 1'b0;
			emit_word(8'h00, 1'b1);
		end else if (pmode == PM_TAG) begin
			tag_step(w.in_byte);
		end else if (pmode == PM_ENT) begin
			entity_step(w.in_byte);
		end else begin
			text_step(w.in_byte);
		end
		if (burst_q.size() > 0) begin
			r = burst_q.pop_back();
			r.run_last = 1'b1;
			burst_q.push_back(r);
		end
		foreach (burst_q[i]) begin
			plain_q.push_back(burst_q[i]);
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t checker: %s got %02h expected %02h", $time, what, got, want);
		errs++;
	endtask

	task automatic check_word(mts_pkg::result_t got);
		mts_pkg::result_t want;
		if (plain_q.size() == 0) begin
			report_mismatch("result word with nothing expected", int'(got.out_byte), 0);
			return;
		end
		want = plain_q.pop_front();
		// The byte field carries no meaning on the done marker.
		if (!want.text_done && got.out_byte != want.out_byte) begin
			report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
		end
		if (got.run_last != want.run_last) begin
			report_mismatch("run_last", int'(got.run_last), int'(want.run_last));
		end
		if (got.text_done != want.text_done) begin
			report_mismatch("text_done", int'(got.text_done), int'(want.text_done));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmode       = PM_TEXT;
			held_n      = 0;
			name_n      = 0;
			name_closed = 1'b0;
			name_over   = 1'b0;
			plain_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				check_word(result);
			end
			if (item_valid && item_ready) begin
				strip_word(item);
			end
		end
		pending    <= plain_q.size();
		fail_count <= errs;
	end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 150;
	localparam int RANDOM_WORDS = 100;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	mts_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	mts_pkg::result_t result;

	int fail_count;
	int pending;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int rx_wait = 0;
	int idle_cycles = 0;
	int sent = 0;

	string tag_names [16] = '{"br", "p", "li", "div", "tr", "ul", "ol", "h1", "h2", "h3",
		"blockquote", "a", "span", "em", "h4", "pre"};
	string ent_names [5] = '{"amp;", "lt;", "gt;", "nbsp;", "quot;"};

	markup_tag_stripper_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	strip_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 45);
	endfunction

	function automatic logic [7:0] any_letter();
		logic [7:0] l;
		l = 8'($urandom_range(8'h61, 8'h7A));
		return $urandom_range(0, 1) ? l - 8'd32 : l;
	endfunction

	function automatic logic [7:0] mixed_case(logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 2) == 0) begin
			return c - 8'd32;
		end
		return c;
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0: c = mts_pkg::CH_SP;
			1: c = $urandom_range(0, 1) ? mts_pkg::CH_TAB : mts_pkg::CH_NL;
			default: begin
				do c = 8'($urandom_range(8'h21, 8'h7E));
				while (c == mts_pkg::CH_LT || c == mts_pkg::CH_AMP);
			end
		endcase
		return c;
	endfunction

	task automatic send_word(mts_pkg::item_t w);
		int g;
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sent++;
		g = calm ? 0 : pick_gap();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_byte(logic [7:0] b);
		mts_pkg::item_t w;
		w.in_byte     = b;
		w.end_of_text = 1'b0;
		send_word(w);
	endtask

	task automatic send_eot();
		mts_pkg::item_t w;
		w.in_byte     = 8'($urandom_range(0, 255));
		w.end_of_text = 1'b1;
		send_word(w);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_tag();
		logic [7:0] frag [$];
		logic [7:0] c;
		string      s;
		int         n;
		int         r;
		frag.push_back(mts_pkg::CH_LT);
		if ($urandom_range(0, 4) == 0) begin
			frag.push_back(mts_pkg::CH_SLASH);
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			s = tag_names[$urandom_range(0, 15)];
			for (int i = 0; i < s.len(); i++) begin
				frag.push_back(mixed_case(s[i]));
			end
		end else begin
			// Random letter names; those around the store size probe the overflow boundary.
			n = (r < 80) ? $urandom_range(1, 6) : $urandom_range(11, 14);
			repeat (n) frag.push_back(any_letter());
		end
		if ($urandom_range(0, 3) == 0) begin
			frag.push_back(mts_pkg::CH_SLASH);
		end
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 2))
				0: frag.push_back(mts_pkg::CH_SP);
				1: frag.push_back(mts_pkg::CH_TAB);
				default: frag.push_back(mts_pkg::CH_NL);
			endcase
			n = $urandom_range(0, 5);
			repeat (n) begin
				do c = 8'($urandom_range(1, 255));
				while (c == mts_pkg::CH_GT);
				frag.push_back(c);
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			frag.push_back(mts_pkg::CH_GT);
		end
		foreach (frag[i]) begin
			send_byte(frag[i]);
		end
	endtask

	task automatic send_fragment();
		string s;
		int    n;
		int    kind;
		kind = $urandom_range(0, 99);
		if (kind < 28) begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(text_char());
		end else if (kind < 55) begin
			send_tag();
		end else if (kind < 75) begin
			send_byte(mts_pkg::CH_AMP);
			s = ent_names[$urandom_range(0, 4)];
			for (int i = 0; i < s.len(); i++) begin
				send_byte(mixed_case(s[i]));
			end
		end else if (kind < 85) begin
			// A cut-short entity followed by whatever byte comes along.
			send_byte(mts_pkg::CH_AMP);
			s = ent_names[$urandom_range(0, 4)];
			n = $urandom_range(0, s.len() - 1);
			for (int i = 0; i < n; i++) begin
				send_byte(mixed_case(s[i]));
			end
			send_byte(8'($urandom_range(1, 255)));
		end else if (kind < 94) begin
			n = $urandom_range(1, 3);
			repeat (n) send_byte(8'($urandom_range(1, 255)));
		end else begin
			send_eot();
		end
	endtask

	initial begin
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_wait > 0) begin
				rx_wait--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				rx_wait = HOLD_CYCLES;
			end else if (!calm && $urandom_range(0, 99) < 25) begin
				result_ready <= 1'b0;
				rx_wait = pick_gap();
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (item_valid && item_ready) ||
				(result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[markup_tag_stripper_top] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Uppercase block tag with a trailing slash, a decoded entity, a broken
		// entity that runs into a tag, the byte extremes, and a held entity
		// prefix flushed by end of text.
		send_text("A<BR/>&Lt;&nb<p>");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_eot();
		send_text("&nbsp");
		send_eot();
		wait_drained();

		// Receiver holds off while the sender keeps going until the block fills.
		calm     = 1'b1;
		hold_req = 1'b1;
		repeat (30) send_byte(any_letter());
		calm = 1'b0;
		wait_drained();

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			calm = (sent >= 40 && sent < 70);
			send_fragment();
		end
		calm = 1'b0;
		send_eot();
		wait_drained();
		repeat (8) @(posedge clk);

		if (fail_count == 0) begin
			$display("[markup_tag_stripper_top] OK");
		end else begin
			$display("[markup_tag_stripper_top] ERROR");
		end
		$finish;
	end

endmodule

### files.f
design/mts_pkg.sv
design/mts_parser.sv
design/mts_burst_buf.sv
design/markup_tag_stripper_top.sv
sim/strip_checker.sv
sim/tb.sv
